>>> hw/rtl/rpra_pkg.sv
// ----------------------------------------------------------------------------
// rpra_pkg
// Types and constants shared by the page run allocator.
// ----------------------------------------------------------------------------
package rpra_pkg;

    localparam int ADDR_W   = 48;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 3;
    localparam int REFCNT_W = 8;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [0:0] {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NO_SPACE  = 3'd1,
        ST_BAD_ADDR  = 3'd2,
        ST_ZERO      = 3'd3,
        ST_CLIPPED   = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REGION_COUNT  = 3'd0,
        REG_REGION0_BASE  = 3'd1,
        REG_REGION0_PAGES = 3'd2,
        REG_REGION1_BASE  = 3'd3,
        REG_REGION1_PAGES = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [0:0]         action;
        logic [COUNT_W-1:0] page_count;
        logic [ADDR_W-1:0]  free_address;
    } request_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   run_address;
        logic [STATUS_W-1:0] status;
    } reply_t;

endpackage

>>> hw/rtl/refcount_page_run_allocator_core.sv
// ----------------------------------------------------------------------------
// refcount_page_run_allocator_core
// First-fit contiguous page allocator with an 8-bit reference count per page.
// ----------------------------------------------------------------------------
// A request transaction is taken when start is high and busy is low. One
// result transaction follows: done is high for exactly one cycle with
// run_address and status on result. The receiver cannot stall; the result
// must be captured on that cycle. Registers are written through cfg_we /
// cfg_index / cfg_data; the user must write them only while idle, which
// the block does not enforce. PAGE_BYTES must be a power of two. After
// reset the count memory is cleared one entry per cycle, and busy stays
// high until all REGIONS*PAGES_PER_REGION entries are clear. A zero count
// or an empty region set goes straight to posting the status. An allocate
// scans the pages of each live region in turn, forms the run address with
// the shared multiplier, raises the count of each allocated page and posts
// the result. A free probes the live regions in turn, forms the page index
// and run end, lowers the count of each released page and posts the result.
// A new request is taken in the cycle done is high.
// ----------------------------------------------------------------------------
module refcount_page_run_allocator_core #(
    parameter int PAGES_PER_REGION = 1024,
    parameter int REGIONS          = 2,
    parameter int PAGE_BYTES       = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  rpra_pkg::request_t                  req,
    output logic                                done,
    output rpra_pkg::reply_t                    result,
    input  logic                                cfg_we,
    input  logic [rpra_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rpra_pkg::ADDR_W-1:0]         cfg_data
);
    import rpra_pkg::*;

    localparam int DEPTH  = REGIONS * PAGES_PER_REGION;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW     = $clog2(PAGES_PER_REGION + 1);
    localparam int MW     = PW + $clog2(PAGE_BYTES + 1);
    localparam int PB_SH  = $clog2(PAGE_BYTES);
    localparam int EW     = ((PW > COUNT_W) ? PW : COUNT_W) + 1;
    localparam int RC_MAX = (REGIONS < 2) ? REGIONS : 2;

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_SCAN  = 11'b00000000100,
        S_AMUL  = 11'b00000001000,
        S_AADD  = 11'b00000010000,
        S_FMUL  = 11'b00000100000,
        S_FCMP  = 11'b00001000000,
        S_FDIV  = 11'b00010000000,
        S_FSET  = 11'b00100000000,
        S_UPD   = 11'b01000000000,
        S_EMIT  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [1:0]         region_count_reg;
    logic [ADDR_W-1:0]  base0_reg, base1_reg;
    logic [COUNT_W-1:0] pages0_reg, pages1_reg;

    // request context
    logic               action_reg, action_next;
    logic [COUNT_W-1:0] num_reg, num_next;
    logic [ADDR_W-1:0]  faddr_reg, faddr_next;
    logic               r_reg, r_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    // scan
    logic [PW-1:0]      scan_j_reg, scan_j_next;
    logic [PW-1:0]      chk_j_reg, chk_j_next;
    logic               chk_vld_reg, chk_vld_next;
    logic [PW-1:0]      run_reg, run_next;

    // update sweep
    logic [PW-1:0]      upd_i_reg, upd_i_next;
    logic [PW-1:0]      upd_hi_reg, upd_hi_next;
    logic               wr_vld_reg, wr_vld_next;
    logic [AW-1:0]      wr_addr_reg, wr_addr_next;

    // shared multiplier and page index
    logic [MW-1:0]      prod_reg, prod_next;
    logic [MW-1:0]      rem_reg, rem_next;
    logic [PW-1:0]      quo_reg, quo_next;

    // clearing pass
    logic [AW-1:0]      clr_reg, clr_next;

    // output
    logic               done_reg, done_next;
    reply_t             result_reg, result_next;

    // memory
    logic [REFCNT_W-1:0] mem [DEPTH];
    logic [REFCNT_W-1:0] rd_data_reg;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    logic [REFCNT_W-1:0] mem_wdata;

    // derived
    logic [1:0]         live_regions;
    logic [COUNT_W-1:0] pages_raw;
    logic [PW-1:0]      np;
    logic [ADDR_W-1:0]  base_r;
    logic [AW-1:0]      region_off;
    logic [PW-1:0]      mul_a;
    logic [MW-1:0]      mul_p;
    logic [PW-1:0]      run_inc;
    logic [EW-1:0]      end_page;
    logic [ADDR_W+1:0]  region_end;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    always_comb
    begin
        if (region_count_reg > 2'(RC_MAX))
            live_regions = 2'(RC_MAX);
        else
            live_regions = region_count_reg;
    end

    assign pages_raw  = r_reg ? pages1_reg : pages0_reg;
    assign np         = (32'(pages_raw) > PAGES_PER_REGION) ? PW'(PAGES_PER_REGION)
                                                            : PW'(pages_raw);
    assign base_r     = r_reg ? base1_reg : base0_reg;
    assign region_off = r_reg ? AW'(PAGES_PER_REGION) : '0;

    // The single multiplier serves both the region end and the run address.
    assign mul_a      = (state_reg == S_AMUL) ? upd_i_reg : np;
    assign mul_p      = MW'(mul_a) * MW'(PAGE_BYTES);
    assign region_end = {2'b00, base_r} + (ADDR_W+2)'(prod_reg);
    assign end_page   = EW'(quo_reg) + EW'(num_reg);
    assign run_inc    = (rd_data_reg == '0) ? run_reg + 1'b1 : '0;

    // Memory port muxing.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = wr_addr_reg;
        mem_wdata = rd_data_reg;
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = '0;
        end
        else if (state_reg == S_UPD && wr_vld_reg)
        begin
            mem_we = 1'b1;
            if (action_reg == ACT_ALLOC)
                mem_wdata = (rd_data_reg == '1) ? rd_data_reg : rd_data_reg + 1'b1;
            else
                mem_wdata = (rd_data_reg == '0) ? rd_data_reg : rd_data_reg - 1'b1;
        end
        if (state_reg == S_SCAN)
            mem_raddr = region_off + AW'(scan_j_reg);
        else
            mem_raddr = region_off + AW'(upd_i_reg);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_count_reg <= 2'd1;
            base0_reg        <= '0;
            base1_reg        <= '0;
            pages0_reg       <= '0;
            pages1_reg       <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_REGION_COUNT:  region_count_reg <= cfg_data[1:0];
                REG_REGION0_BASE:  base0_reg        <= cfg_data;
                REG_REGION0_PAGES: pages0_reg       <= cfg_data[COUNT_W-1:0];
                REG_REGION1_BASE:  base1_reg        <= cfg_data;
                REG_REGION1_PAGES: pages1_reg       <= cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        action_next  = action_reg;
        num_next     = num_reg;
        faddr_next   = faddr_reg;
        r_next       = r_reg;
        addr_next    = addr_reg;
        status_next  = status_reg;
        scan_j_next  = scan_j_reg;
        chk_j_next   = chk_j_reg;
        chk_vld_next = 1'b0;
        run_next     = run_reg;
        upd_i_next   = upd_i_reg;
        upd_hi_next  = upd_hi_reg;
        wr_vld_next  = 1'b0;
        wr_addr_next = wr_addr_reg;
        prod_next    = prod_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        clr_next     = clr_reg;
        done_next    = 1'b0;
        result_next  = result_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == DEPTH - 1)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    action_next = req.action;
                    num_next    = req.page_count;
                    faddr_next  = req.free_address;
                    r_next      = 1'b0;
                    addr_next   = '0;
                    scan_j_next = '0;
                    run_next    = '0;
                    if (req.page_count == '0)
                    begin
                        status_next = ST_ZERO;
                        state_next  = S_EMIT;
                    end
                    else if (live_regions == 2'd0)
                    begin
                        status_next = (req.action == ACT_ALLOC) ? ST_NO_SPACE : ST_BAD_ADDR;
                        state_next  = S_EMIT;
                    end
                    else if (req.action == ACT_ALLOC)
                        state_next = S_SCAN;
                    else
                        state_next = S_FMUL;
                end
            end
            S_SCAN:
            begin
                // Reads are issued one page ahead of the zero-run check.
                if (chk_vld_reg && EW'(run_inc) == EW'(num_reg))
                begin
                    upd_i_next  = PW'(EW'(chk_j_reg) + EW'(1) - EW'(num_reg));
                    upd_hi_next = chk_j_reg + 1'b1;
                    state_next  = S_AMUL;
                end
                else
                begin
                    if (chk_vld_reg)
                        run_next = run_inc;
                    if (scan_j_reg < np)
                    begin
                        chk_vld_next = 1'b1;
                        chk_j_next   = scan_j_reg;
                        scan_j_next  = scan_j_reg + 1'b1;
                    end
                    else if (!r_reg && live_regions == 2'd2)
                    begin
                        r_next      = 1'b1;
                        scan_j_next = '0;
                        run_next    = '0;
                    end
                    else
                    begin
                        status_next = ST_NO_SPACE;
                        state_next  = S_EMIT;
                    end
                end
            end
            S_AMUL:
            begin
                prod_next  = mul_p;
                state_next = S_AADD;
            end
            S_AADD:
            begin
                addr_next   = base_r + ADDR_W'(prod_reg);
                status_next = ST_OK;
                state_next  = S_UPD;
            end
            S_FMUL:
            begin
                prod_next  = mul_p;
                state_next = S_FCMP;
            end
            S_FCMP:
            begin
                if (base_r <= faddr_reg && {2'b00, faddr_reg} < region_end)
                begin
                    rem_next   = MW'(faddr_reg - base_r);
                    state_next = S_FDIV;
                end
                else if (!r_reg && live_regions == 2'd2)
                begin
                    r_next     = 1'b1;
                    state_next = S_FMUL;
                end
                else
                begin
                    status_next = ST_BAD_ADDR;
                    state_next  = S_EMIT;
                end
            end
            S_FDIV:
            begin
                // The page size is a power of two, so the page index is a shift.
                quo_next   = PW'(rem_reg >> PB_SH);
                state_next = S_FSET;
            end
            S_FSET:
            begin
                upd_i_next = quo_reg;
                if (end_page > EW'(np))
                begin
                    upd_hi_next = np;
                    status_next = ST_CLIPPED;
                end
                else
                begin
                    upd_hi_next = PW'(end_page);
                    status_next = ST_OK;
                end
                state_next = S_UPD;
            end
            S_UPD:
            begin
                // Read one page while the previous page is written back.
                if (upd_i_reg < upd_hi_reg)
                begin
                    wr_vld_next  = 1'b1;
                    wr_addr_next = mem_raddr;
                    upd_i_next   = upd_i_reg + 1'b1;
                end
                else if (!wr_vld_reg)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                done_next               = 1'b1;
                result_next.run_address = addr_reg;
                result_next.status      = status_reg;
                state_next              = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            chk_vld_reg <= 1'b0;
            wr_vld_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            chk_vld_reg <= chk_vld_next;
            wr_vld_reg  <= wr_vld_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg  <= action_next;
        num_reg     <= num_next;
        faddr_reg   <= faddr_next;
        r_reg       <= r_next;
        addr_reg    <= addr_next;
        status_reg  <= status_next;
        scan_j_reg  <= scan_j_next;
        chk_j_reg   <= chk_j_next;
        run_reg     <= run_next;
        upd_i_reg   <= upd_i_next;
        upd_hi_reg  <= upd_hi_next;
        wr_addr_reg <= wr_addr_next;
        prod_reg    <= prod_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        result_reg  <= result_next;
    end

endmodule

>>> bench/refcount_page_run_allocator_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// refcount_page_run_allocator_core_test
// Self-checking bench for the page run allocator. A directed table, then
// random allocate and free transactions over several region setups and
// idling phases, all checked against a behavioral model of the counts.
// ----------------------------------------------------------------------------
module refcount_page_run_allocator_core_test;
    import rpra_pkg::*;

    localparam int NPAGES = 1024;
    localparam int NREG   = 2;
    localparam int PBYTES = 4096;
    localparam int CYCLE_LIMIT = 6000000;

    typedef struct {
        request_t req;
        logic     known;
        reply_t   res;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    request_t req = '0;
    logic done;
    reply_t result;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ADDR_W-1:0] cfg_data = '0;

    logic [REFCNT_W-1:0] counts [NREG*NPAGES];
    logic [1:0]          m_region_count;
    logic [ADDR_W-1:0]   m_base [2];
    logic [COUNT_W-1:0]  m_pages [2];

    reply_t pending [$];
    int errors = 0;
    int n_items = 0;
    int n_results = 0;
    int cycles = 0;
    int send_idle = 0;

    refcount_page_run_allocator_core uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("refcount_page_run_allocator_core verification failed");
            $finish;
        end
    end

    function automatic int pages_in(int r);
        return (m_pages[r] > NPAGES) ? NPAGES : int'(m_pages[r]);
    endfunction

    function automatic int regions_live();
        return (m_region_count > 2) ? 2 : int'(m_region_count);
    endfunction

    // Predicts the result of one request and updates the count copy.
    function automatic reply_t allocate_or_free(request_t rq);
        reply_t o;
        int nr, np, run, first, r, j;
        logic [ADDR_W:0] lim;
        longint idx, endp;
        nr = regions_live();
        o.run_address = '0;
        if (rq.page_count == 0)
        begin
            o.status = ST_ZERO;
            return o;
        end
        if (rq.action == ACT_ALLOC)
        begin
            o.status = ST_NO_SPACE;
            for (r = 0; r < nr; r++)
            begin
                np = pages_in(r);
                run = 0;
                for (j = 0; j < np; j++)
                begin
                    run = (counts[r*NPAGES+j] == 0) ? run + 1 : 0;
                    if (run == int'(rq.page_count))
                    begin
                        first = j + 1 - run;
                        for (int k = first; k <= j; k++)
                            if (counts[r*NPAGES+k] != 8'hFF)
                                counts[r*NPAGES+k]++;
                        o.run_address = m_base[r] + ADDR_W'(PBYTES) * ADDR_W'(first);
                        o.status = ST_OK;
                        return o;
                    end
                end
            end
            return o;
        end
        for (r = 0; r < nr; r++)
        begin
            // The region end is computed one bit wider so it cannot wrap.
            lim = {1'b0, m_base[r]} + (ADDR_W+1)'(pages_in(r)) * PBYTES;
            if (m_base[r] <= rq.free_address && {1'b0, rq.free_address} < lim)
                break;
        end
        if (r >= nr)
        begin
            o.status = ST_BAD_ADDR;
            return o;
        end
        idx = longint'((rq.free_address - m_base[r]) / PBYTES);
        endp = idx + rq.page_count;
        o.status = ST_OK;
        if (endp > pages_in(r))
        begin
            endp = pages_in(r);
            o.status = ST_CLIPPED;
        end
        for (longint i = idx; i < endp; i++)
            if (counts[r*NPAGES+i] != 0)
                counts[r*NPAGES+i]--;
        return o;
    endfunction

    always @(posedge clk)
    begin
        reply_t exp_r;
        if (done)
        begin
            n_results <= n_results + 1;
            if (pending.size() == 0)
            begin
                $error("result transaction with nothing expected");
                errors++;
            end
            else
            begin
                exp_r = pending.pop_front();
                if (result.run_address !== exp_r.run_address)
                begin
                    $error("run_address expected %h actual %h",
                        exp_r.run_address, result.run_address);
                    errors++;
                end
                if (result.status !== exp_r.status)
                begin
                    $error("status expected %0d actual %0d", exp_r.status, result.status);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [ADDR_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_REGION_COUNT:  m_region_count = val[1:0];
            REG_REGION0_BASE:  m_base[0] = val;
            REG_REGION0_PAGES: m_pages[0] = val[COUNT_W-1:0];
            REG_REGION1_BASE:  m_base[1] = val;
            REG_REGION1_PAGES: m_pages[1] = val[COUNT_W-1:0];
            default: ;
        endcase
    endtask

    // Stops requesting and waits until every transaction has answered.
    task automatic drain();
        start <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic setup(int cnt, logic [ADDR_W-1:0] b0, int p0,
                         logic [ADDR_W-1:0] b1, int p1);
        drain();
        write_reg(REG_REGION_COUNT, ADDR_W'(cnt));
        write_reg(REG_REGION0_BASE, b0);
        write_reg(REG_REGION0_PAGES, ADDR_W'(p0));
        write_reg(REG_REGION1_BASE, b1);
        write_reg(REG_REGION1_PAGES, ADDR_W'(p1));
        // An index above the last register must change nothing.
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= 3'd7;
        cfg_data <= '1;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Start stays high after an accept so the next request can follow at once.
    task automatic send(request_t rq, logic known, reply_t want);
        reply_t p;
        int n_idle;
        n_idle = ($urandom_range(99) < send_idle) ? int'($urandom_range(1, 4)) : 0;
        if (n_idle > 0)
        begin
            start <= 1'b0;
            repeat (n_idle) @(posedge clk);
        end
        start <= 1'b1;
        req <= rq;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        p = allocate_or_free(rq);
        if (known && p !== want)
        begin
            $error("table row expected %h actual %h", want, p);
            errors++;
        end
        pending.push_back(p);
        n_items++;
    endtask

    function automatic request_t mk(action_t a, int n, logic [ADDR_W-1:0] ad);
        request_t rq;
        rq.action = a;
        rq.page_count = COUNT_W'(n);
        rq.free_address = ad;
        return rq;
    endfunction

    function automatic reply_t rs(logic [ADDR_W-1:0] ad, status_t st);
        reply_t o;
        o.run_address = ad;
        o.status = st;
        return o;
    endfunction

    // Random request biased toward the configured regions and small runs.
    function automatic request_t random_req();
        request_t rq;
        int r;
        rq.action = action_t'($urandom_range(1));
        case ($urandom_range(9))
            0: rq.page_count = 0;
            1: rq.page_count = COUNT_W'($urandom_range(2047));
            2: rq.page_count = 1024;
            default: rq.page_count = COUNT_W'($urandom_range(1, 12));
        endcase
        r = $urandom_range(1);
        if ($urandom_range(9) < 8)
            rq.free_address = m_base[r] +
                              ADDR_W'($urandom_range(pages_in(r) * PBYTES + 8192));
        else
            rq.free_address = ADDR_W'({$urandom, $urandom});
        return rq;
    endfunction

    row_t tbl [$];

    initial
    begin
        int phase_items;
        m_region_count = 1;
        m_base = '{default: '0};
        m_pages = '{default: '0};
        foreach (counts[i])
            counts[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // After reset no region has pages.
        tbl.push_back('{mk(ACT_ALLOC, 1, 0), 1'b1, rs(0, ST_NO_SPACE)});
        tbl.push_back('{mk(ACT_FREE, 1, 0), 1'b1, rs(0, ST_BAD_ADDR)});
        tbl.push_back('{mk(ACT_ALLOC, 0, 0), 1'b1, rs(0, ST_ZERO)});
        foreach (tbl[i])
            send(tbl[i].req, tbl[i].known, tbl[i].res);
        tbl.delete();

        setup(2, 48'h0000_0010_0000, 16, 48'hFFFF_FFFF_F000, 2047);
        tbl.push_back('{mk(ACT_ALLOC, 1, 0), 1'b1, rs(48'h0000_0010_0000, ST_OK)});
        tbl.push_back('{mk(ACT_ALLOC, 15, 0), 1'b1, rs(48'h0000_0010_1000, ST_OK)});
        tbl.push_back('{mk(ACT_ALLOC, 1, 0), 1'b1, rs(48'hFFFF_FFFF_F000, ST_OK)});
        tbl.push_back('{mk(ACT_ALLOC, 2047, 0), 1'b1, rs(0, ST_NO_SPACE)});
        tbl.push_back('{mk(ACT_ALLOC, 1023, 0), 1'b0, rs(0, ST_OK)});
        tbl.push_back('{mk(ACT_FREE, 0, 48'h0000_0010_0000), 1'b1, rs(0, ST_ZERO)});
        tbl.push_back('{mk(ACT_FREE, 4, 48'h0000_0010_E123), 1'b1, rs(0, ST_CLIPPED)});
        tbl.push_back('{mk(ACT_FREE, 2047, 48'h0000_0010_0000), 1'b1, rs(0, ST_CLIPPED)});
        tbl.push_back('{mk(ACT_FREE, 3, 48'hFFFF_FFFF_FFFF), 1'b1, rs(0, ST_OK)});
        tbl.push_back('{mk(ACT_FREE, 1, 48'h0000_0011_0000), 1'b1, rs(0, ST_BAD_ADDR)});
        tbl.push_back('{mk(ACT_FREE, 1, 48'h0000_000F_FFFF), 1'b1, rs(0, ST_BAD_ADDR)});
        tbl.push_back('{mk(ACT_ALLOC, 16, 0), 1'b0, rs(0, ST_OK)});
        tbl.push_back('{mk(ACT_ALLOC, 0, 48'hFFFF_FFFF_FFFF), 1'b1, rs(0, ST_ZERO)});
        foreach (tbl[i])
            send(tbl[i].req, tbl[i].known, tbl[i].res);
        tbl.delete();

        // A region count of zero disables every region.
        setup(0, 0, 8, 0, 8);
        send(mk(ACT_ALLOC, 1, 0), 1'b1, rs(0, ST_NO_SPACE));
        send(mk(ACT_FREE, 1, 0), 1'b1, rs(0, ST_BAD_ADDR));
        // A count of three is used as two; region 1 overlaps region 0.
        setup(3, 48'h0000_1234_5678, 4, 48'h0000_1234_5000, 1024);
        send(mk(ACT_ALLOC, 5, 0), 1'b0, rs(0, ST_OK));
        send(mk(ACT_FREE, 2, 48'h0000_1234_5678), 1'b0, rs(0, ST_OK));

        // Random part: one phase per idling level and region setup.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle = 0;  setup(2, 48'h8000_0000, 24, 48'h4000_0000, 40); end
                1: begin send_idle = 67; setup(1, 48'h0, 32, 48'h0, 0); end
                2: begin send_idle = 29;
                         setup(2, ADDR_W'({$urandom, $urandom}) & 48'hFFFF_FFFF_F000,
                               $urandom_range(1, 48),
                               ADDR_W'({$urandom, $urandom}), $urandom_range(1, 48)); end
                default: begin send_idle = 0; setup(2, 0, 1024, 48'h40_0000, 1024); end
            endcase
            phase_items = (ph == 3) ? 20 : 90;
            repeat (phase_items)
                send(random_req(), 1'b0, rs(0, ST_OK));
        end

        drain();
        $display("Ran %0d requests and compared %0d answers, covering reset, zero regions,",
                 n_items, n_results);
        $display("clipped and bad frees, overlapping regions and sender gaps of 0/29/67 pct.");
        if (errors == 0)
            $display("refcount_page_run_allocator_core verification clean");
        else
            $display("refcount_page_run_allocator_core verification failed");
        $finish;
    end

endmodule
